FILE: src/charge_source_selector_unit_assert.svh
// assertion macros shared by the checker
`ifndef CHARGE_SOURCE_SELECTOR_UNIT_ASSERT_SVH
`define CHARGE_SOURCE_SELECTOR_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define CSS_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define CSS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/css_pkg.sv
`timescale 1ns / 1ps

package css_pkg;

   typedef enum logic [1:0] {
      SRC_UNSET   = 2'd0,
      SRC_SUN     = 2'd1,
      SRC_MAINS   = 2'd2,
      SRC_BATTERY = 2'd3
   } source_type;

   typedef enum logic [2:0] {
      ALERT_CLEAR    = 3'd0,
      ALERT_HOT      = 3'd1,
      ALERT_LOW      = 3'd2,
      ALERT_NOSOURCE = 3'd3,
      ALERT_CRITICAL = 3'd4
   } alert_type;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 20;

   localparam logic [CsrAddrWidth-1:0] CSR_FULL_LEVEL     = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_LOW_LEVEL      = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_CRITICAL_LEVEL = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_DWELL          = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CSR_HOT_LIMIT      = 3'd4;

   localparam logic [15:0] FULL_LEVEL_RESET     = 16'd14400;
   localparam logic [15:0] LOW_LEVEL_RESET      = 16'd11800;
   localparam logic [15:0] CRITICAL_LEVEL_RESET = 16'd11000;
   localparam logic [19:0] DWELL_RESET          = 20'd5000;
   localparam logic signed [11:0] HOT_LIMIT_RESET = 12'sd600;

   localparam logic [31:0] FRESH_WINDOW_MS = 32'd10000;

   localparam int unsigned ReqDataWidth = 96;
   localparam int unsigned RspDataWidth = 40;

   // first field in the highest bits
   typedef struct packed {
      logic signed [11:0] temp_decic;
      logic [31:0]        temp_read_ms;
      logic               temp_ok;
      logic [15:0]        battery_mv;
      logic               grid_seen;
      logic               daylight;
      logic               solar_seen;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  pad;
      alert_type   alert_code;
      logic [31:0] changed_at_ms;
      logic        relay_closed;
      source_type  source_now;
   } rsp_type;

endpackage

FILE: src/charge_source_selector_unit.sv
`timescale 1ns / 1ps

// Charge source selector: one sensor sample in per request, one status result out per
// request. A request is held in an input register and evaluated into the result register
// once that register is empty or being read, so the block takes one request per clock when
// not stalled; the result register lets a new request enter while a result waits on rsp_tready.
// Solar is chosen when present in daylight, grid when present below the full level, else
// battery; a new source is committed only after it has persisted for dwell_ms. Registers
// are written through the csr_ port and should only change while no request is in flight.
module charge_source_selector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms, solar_seen, daylight, grid_seen, battery_mv, temp_ok, temp_read_ms, temp_decic
   input  logic [css_pkg::ReqDataWidth-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // source_now, relay_closed, changed_at_ms, alert_code, two zero bits
   output logic [css_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [css_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [css_pkg::CsrDataWidth-1:0] csr_wdata
);

   logic [15:0]        full_level_ff;
   logic [15:0]        low_level_ff;
   logic [15:0]        critical_level_ff;
   logic [19:0]        dwell_ff;
   logic signed [11:0] hot_limit_ff;

   logic                in_valid_ff;
   css_pkg::req_type    in_data_ff;
   logic                out_valid_ff;
   css_pkg::rsp_type    out_data_ff;
   css_pkg::rsp_type    out_data_in;

   css_pkg::source_type active_ff, active_in;
   logic                relay_ff, relay_in;
   logic [31:0]         change_time_ff, change_time_in;
   css_pkg::source_type cand_ff, cand_in;
   logic [31:0]         cand_since_ff, cand_since_in;

   css_pkg::source_type desired;
   css_pkg::alert_type  alert;
   logic [31:0]         dwell_elapsed;
   logic [31:0]         temp_age;
   logic                advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         full_level_ff     <= css_pkg::FULL_LEVEL_RESET;
         low_level_ff      <= css_pkg::LOW_LEVEL_RESET;
         critical_level_ff <= css_pkg::CRITICAL_LEVEL_RESET;
         dwell_ff          <= css_pkg::DWELL_RESET;
         hot_limit_ff      <= css_pkg::HOT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            css_pkg::CSR_FULL_LEVEL:     full_level_ff     <= csr_wdata[15:0];
            css_pkg::CSR_LOW_LEVEL:      low_level_ff      <= csr_wdata[15:0];
            css_pkg::CSR_CRITICAL_LEVEL: critical_level_ff <= csr_wdata[15:0];
            css_pkg::CSR_DWELL:          dwell_ff          <= csr_wdata;
            css_pkg::CSR_HOT_LIMIT:      hot_limit_ff      <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // source selection and alerts
   always_comb begin
      active_in      = active_ff;
      relay_in       = relay_ff;
      change_time_in = change_time_ff;
      cand_in        = cand_ff;
      cand_since_in  = cand_since_ff;

      if (in_data_ff.solar_seen && in_data_ff.daylight) begin
         desired = css_pkg::SRC_SUN;
      end else if (in_data_ff.grid_seen && (in_data_ff.battery_mv < full_level_ff)) begin
         desired = css_pkg::SRC_MAINS;
      end else begin
         desired = css_pkg::SRC_BATTERY;
      end

      dwell_elapsed = in_data_ff.now_ms - cand_since_ff;

      if (desired == active_ff) begin
         cand_in       = active_ff;
         cand_since_in = 32'd0;
      end else if (desired != cand_ff) begin
         cand_in       = desired;
         cand_since_in = in_data_ff.now_ms;
      end else if (dwell_elapsed >= {12'd0, dwell_ff}) begin
         active_in      = desired;
         relay_in       = (desired == css_pkg::SRC_MAINS);
         change_time_in = in_data_ff.now_ms;
      end

      temp_age = in_data_ff.now_ms - in_data_ff.temp_read_ms;
      alert    = css_pkg::ALERT_CLEAR;
      if (in_data_ff.temp_ok && (temp_age <= css_pkg::FRESH_WINDOW_MS)
          && (in_data_ff.temp_decic > hot_limit_ff)) begin
         alert = css_pkg::ALERT_HOT;
      end
      if (in_data_ff.battery_mv <= low_level_ff) begin
         alert = (active_in == css_pkg::SRC_BATTERY) ? css_pkg::ALERT_NOSOURCE
                                                     : css_pkg::ALERT_LOW;
      end
      if (in_data_ff.battery_mv <= critical_level_ff) begin
         alert = css_pkg::ALERT_CRITICAL;
      end

      out_data_in.pad           = 2'b00;
      out_data_in.alert_code    = alert;
      out_data_in.changed_at_ms = change_time_in;
      out_data_in.relay_closed  = relay_in;
      out_data_in.source_now    = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         active_ff      <= css_pkg::SRC_UNSET;
         relay_ff       <= 1'b0;
         change_time_ff <= 32'd0;
         cand_ff        <= css_pkg::SRC_UNSET;
         cand_since_ff  <= 32'd0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff   <= 1'b1;
            active_ff      <= active_in;
            relay_ff       <= relay_in;
            change_time_ff <= change_time_in;
            cand_ff        <= cand_in;
            cand_since_ff  <= cand_since_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= css_pkg::req_type'(req_tdata);
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

FILE: src/css_checker.sv
`timescale 1ns / 1ps

`include "charge_source_selector_unit_assert.svh"

module css_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [css_pkg::RspDataWidth-1:0] rsp_tdata
);

   css_pkg::rsp_type rsp;
   logic             rsp_on_mains;
   logic             rsp_unset;
   logic             rsp_untouched;
   logic             rsp_alert_ok;

   assign rsp           = css_pkg::rsp_type'(rsp_tdata);
   assign rsp_on_mains  = (rsp.source_now == css_pkg::SRC_MAINS);
   assign rsp_unset     = (rsp.source_now == css_pkg::SRC_UNSET);
   assign rsp_untouched = !rsp.relay_closed && (rsp.changed_at_ms == 32'd0);
   assign rsp_alert_ok  = (rsp.pad == 2'b00) && (rsp.alert_code <= css_pkg::ALERT_CRITICAL);

   `CSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   `CSS_ASSERT_SAME(a_relay_grid, clock, reset, rsp_tvalid && rsp.relay_closed, rsp_on_mains)

   `CSS_ASSERT_SAME(a_none_clean, clock, reset, rsp_tvalid && rsp_unset, rsp_untouched)

   `CSS_ASSERT_SAME(a_alert_range, clock, reset, rsp_tvalid, rsp_alert_ok)

endmodule

bind charge_source_selector_unit css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
